FILE: rtl/png_scanline_unfilter_top_assert.svh
// Assertion macros for the PNG scanline unfilter block.
`ifndef PNG_SCANLINE_UNFILTER_TOP_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PNGU_AST_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("pngu assertion failed");
// next-cycle implication
`define PNGU_AST_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("pngu assertion failed");
`else
`define PNGU_AST_IMP(lbl, clk, rstn, ante, cons)
`define PNGU_AST_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/pngu_pkg.sv
// Shared constants and types for the PNG scanline unfilter.
package pngu_pkg;
	localparam int MAX_ROW_BYTES   = 16384;
	localparam int MAX_PIXEL_BYTES = 8;

	localparam int BYTE_W      = 8;
	localparam int ROW_BYTES_W = 15;
	localparam int BPP_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int FILT_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd1;

	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 15'd3;
	localparam logic [BPP_W-1:0]       BPP_RST       = 4'd3;

	localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
	localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
	localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
	localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
	localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;
	localparam logic [FILT_W-1:0] FILT_BAD   = 3'd5;

	typedef struct packed {
		logic [FILT_W-1:0] filter;
		logic              has_left;
		logic              last;
	} s1_ctrl_t;
endpackage

FILE: rtl/pngu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pngu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/pngu_recon.sv
// Predictor and reconstruction adder for the five PNG filter types.
module pngu_recon (
	input  pngu_pkg::s1_ctrl_t               ctrl,
	input  logic [pngu_pkg::BYTE_W-1:0]      x,
	input  logic [pngu_pkg::BYTE_W-1:0]      left,
	input  logic [pngu_pkg::BYTE_W-1:0]      up,
	input  logic [pngu_pkg::BYTE_W-1:0]      diag,
	output logic [pngu_pkg::BYTE_W-1:0]      recon
);
	localparam int SW = pngu_pkg::BYTE_W + 2;

	logic signed [SW-1:0] a_s, b_s, c_s;
	logic signed [SW-1:0] da, db, dc;
	logic [SW-1:0]        pa, pb, pc;
	logic [pngu_pkg::BYTE_W-1:0] paeth_pred;
	logic [pngu_pkg::BYTE_W:0]   avg_sum;
	logic [pngu_pkg::BYTE_W-1:0] pred;

	// p - a = b - c, p - b = a - c, p - c = a + b - 2c
	always_comb begin
		a_s = signed'(SW'(left));
		b_s = signed'(SW'(up));
		c_s = signed'(SW'(diag));
		da  = b_s - c_s;
		db  = a_s - c_s;
		dc  = a_s + b_s - c_s - c_s;
		pa  = (da < 0) ? unsigned'(-da) : unsigned'(da);
		pb  = (db < 0) ? unsigned'(-db) : unsigned'(db);
		pc  = (dc < 0) ? unsigned'(-dc) : unsigned'(dc);
		if (pa <= pb && pa <= pc) begin
			paeth_pred = left;
		end else if (pb <= pc) begin
			paeth_pred = up;
		end else begin
			paeth_pred = diag;
		end
	end

	always_comb begin
		avg_sum = {1'b0, left} + {1'b0, up};
		case (ctrl.filter)
			pngu_pkg::FILT_SUB:   pred = left;
			pngu_pkg::FILT_UP:    pred = up;
			pngu_pkg::FILT_AVG:   pred = avg_sum[pngu_pkg::BYTE_W:1];
			pngu_pkg::FILT_PAETH: pred = paeth_pred;
			default:              pred = '0;
		endcase
		recon = x + pred;
	end
endmodule

FILE: rtl/png_scanline_unfilter_top.sv
// Top level of the PNG scanline unfilter: row tracking, prior-row RAM, history, output.
//
// channel  direction  signals
// cfg      in         cfg_valid / cfg_ready, cfg_index, cfg_data
// in       in         in_valid / in_ready, stream_byte
// out      out        out_valid / out_ready, pixel_byte, row_end, bad_filter
//
// One byte per cycle while out_ready holds; data passes s1, then the output register.
// The prior-row RAM is read when a data byte is taken and written as it leaves s1;
// a write to the entry being read in the same cycle is forwarded.
// Unwritten prior-row entries read as zero through a fill count, so no clearing pass.
// A stalled output holds the reconstruction stage; filter bytes are still taken then.
`include "png_scanline_unfilter_top_assert.svh"
module png_scanline_unfilter_top #(
	parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES,
	parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pngu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pngu_pkg::ROW_BYTES_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pngu_pkg::BYTE_W-1:0]         stream_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pngu_pkg::BYTE_W-1:0]         pixel_byte,
	output logic                                row_end,
	output logic                                bad_filter
);
	localparam int AW  = $clog2(MAX_ROW_BYTES);
	localparam int FW  = $clog2(MAX_ROW_BYTES + 1);
	localparam int CW  = (FW > pngu_pkg::ROW_BYTES_W) ? FW : pngu_pkg::ROW_BYTES_W;
	localparam int PW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int BW0 = $clog2(MAX_PIXEL_BYTES + 1);
	localparam int BX  = (BW0 > pngu_pkg::BPP_W) ? BW0 : pngu_pkg::BPP_W;
	localparam int B   = pngu_pkg::BYTE_W;

	// configuration
	logic [pngu_pkg::ROW_BYTES_W-1:0] row_bytes_q;
	logic [pngu_pkg::BPP_W-1:0]       bpp_q;

	// row tracking
	logic                          awaiting_q;
	logic [pngu_pkg::FILT_W-1:0]   row_filter_q;
	logic [AW-1:0]                 col_q;
	logic [FW-1:0]                 fill_q;

	// reconstruction stage
	logic                 s1_valid_s1;
	logic [B-1:0]         x_s1;
	logic [AW-1:0]        pos_s1;
	pngu_pkg::s1_ctrl_t   ctrl_s1;
	logic                 upok_s1;
	logic                 fwd_s1;
	logic [B-1:0]         fwdd_s1;

	logic [B-1:0] left_h_q [MAX_PIXEL_BYTES];
	logic [B-1:0] ul_h_q   [MAX_PIXEL_BYTES];

	logic          out_valid_q;
	logic [B-1:0]  pixel_q;
	logic          row_end_q;
	logic          bad_q;

	logic [CW-1:0] rb_ext, len_c, col_ext, pos_c, pos_inc;
	logic [BX-1:0] bp_ext, bpp_c;
	logic [PW-1:0] bidx;
	logic [AW-1:0] pos;
	logic          last_c, has_left_c, upok_c;
	logic          in_acc, data_acc, type_acc, s1_adv;
	logic [B-1:0]  rdata, up, left, diag, recon;
	pngu_pkg::s1_ctrl_t ctrl_c;

	always_comb begin
		rb_ext = CW'(row_bytes_q);
		if (rb_ext == '0) begin
			len_c = CW'(1);
		end else if (rb_ext > CW'(MAX_ROW_BYTES)) begin
			len_c = CW'(MAX_ROW_BYTES);
		end else begin
			len_c = rb_ext;
		end
		col_ext = CW'(col_q);
		pos_c   = (col_ext >= len_c) ? len_c - CW'(1) : col_ext;
		pos_inc = pos_c + CW'(1);
		pos     = pos_c[AW-1:0];
		last_c  = pos_inc >= len_c;

		bp_ext = BX'(bpp_q);
		if (bp_ext == '0) begin
			bpp_c = BX'(1);
		end else if (bp_ext > BX'(MAX_PIXEL_BYTES)) begin
			bpp_c = BX'(MAX_PIXEL_BYTES);
		end else begin
			bpp_c = bp_ext;
		end
		bidx       = PW'(bpp_c - BX'(1));
		has_left_c = CW'(bpp_c) <= pos_c;
		upok_c     = FW'(pos) < fill_q;

		ctrl_c.filter   = row_filter_q;
		ctrl_c.has_left = has_left_c;
		ctrl_c.last     = last_c;
	end

	assign s1_adv    = s1_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = awaiting_q || !s1_valid_s1 || s1_adv;
	assign in_acc    = in_valid && in_ready;
	assign data_acc  = in_acc && !awaiting_q;
	assign type_acc  = in_acc && awaiting_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= pngu_pkg::ROW_BYTES_RST;
			bpp_q       <= pngu_pkg::BPP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pngu_pkg::REG_ROW_BYTES: row_bytes_q <= cfg_data;
				pngu_pkg::REG_BPP:       bpp_q <= cfg_data[pngu_pkg::BPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b1;
			row_filter_q <= pngu_pkg::FILT_NONE;
			col_q        <= '0;
		end else if (type_acc) begin
			row_filter_q <= (stream_byte <= B'(pngu_pkg::FILT_PAETH)) ?
				stream_byte[pngu_pkg::FILT_W-1:0] : pngu_pkg::FILT_BAD;
			col_q        <= '0;
			awaiting_q   <= 1'b0;
		end else if (data_acc) begin
			if (last_c) begin
				col_q      <= '0;
				awaiting_q <= 1'b1;
			end else begin
				col_q <= pos_inc[AW-1:0];
			end
		end
	end

	pngu_ram #(
		.WIDTH(B),
		.DEPTH(MAX_ROW_BYTES)
	) u_prior_row (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(pos_s1),
		.wdata(recon),
		.re   (data_acc),
		.raddr(pos),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (data_acc) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			x_s1    <= stream_byte;
			pos_s1  <= pos;
			ctrl_s1 <= ctrl_c;
			upok_s1 <= upok_c;
			// same entry written by the retiring byte in this cycle
			fwd_s1  <= s1_adv && (pos_s1 == pos);
			fwdd_s1 <= recon;
		end
	end

	// written entries always form a prefix of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (s1_adv && FW'(pos_s1) >= fill_q) begin
			fill_q <= FW'(pos_s1) + FW'(1);
		end
	end

	always_comb begin
		up   = fwd_s1 ? fwdd_s1 : (upok_s1 ? rdata : '0);
		left = ctrl_s1.has_left ? left_h_q[bidx] : '0;
		diag = ctrl_s1.has_left ? ul_h_q[bidx] : '0;
	end

	pngu_recon u_recon (
		.ctrl (ctrl_s1),
		.x    (x_s1),
		.left (left),
		.up   (up),
		.diag (diag),
		.recon(recon)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
				left_h_q[k] <= '0;
				ul_h_q[k]   <= '0;
			end
		end else if (s1_adv) begin
			for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
				left_h_q[k] <= left_h_q[k-1];
				ul_h_q[k]   <= ul_h_q[k-1];
			end
			left_h_q[0] <= recon;
			ul_h_q[0]   <= up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_q   <= recon;
			row_end_q <= ctrl_s1.last;
			bad_q     <= (ctrl_s1.filter == pngu_pkg::FILT_BAD);
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_q;
	assign row_end    = row_end_q;
	assign bad_filter = bad_q;

	`PNGU_AST_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FW'(MAX_ROW_BYTES))
	`PNGU_AST_IMP(a_type_ready, clk, arst_n, awaiting_q, in_ready)
	`PNGU_AST_NXT(a_last_rearm, clk, arst_n, data_acc && last_c, awaiting_q)
	`PNGU_AST_NXT(a_out_load, clk, arst_n, s1_adv, out_valid && pixel_byte == $past(recon))
endmodule

FILE: tb/sv/tb_png_scanline_unfilter_top.sv
// Testbench for the PNG scanline unfilter: directed table, random rows, predictor-based checks.
`timescale 1ns / 100ps

module tb_png_scanline_unfilter_top;
	import pngu_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_ITEMS  = 1750;
	localparam int LAT_IDLE    = 8;
	localparam int LONG_HOLD   = 400;
	localparam int DIR_N       = 29;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED3 = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] pixel;
		logic              last;
		logic              bad;
	} pix_t;

	typedef enum bit {DIR_REG, DIR_BYTE} dir_kind_t;

	typedef struct {
		dir_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [ROW_BYTES_W-1:0] val;
		logic                   typed;
		pix_t                   want;
	} dir_row_t;

	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [ROW_BYTES_W-1:0] cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [BYTE_W-1:0]      stream_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic [BYTE_W-1:0]      pixel_byte;
	logic                   row_end;
	logic                   bad_filter;

	// predictor state
	logic [ROW_BYTES_W-1:0] rowlen_reg = ROW_BYTES_RST;
	logic [BPP_W-1:0]       bpp_reg = BPP_RST;
	logic [BYTE_W-1:0]      prev_line [MAX_ROW_BYTES];
	logic [BYTE_W-1:0]      left_hist [MAX_PIXEL_BYTES];
	logic [BYTE_W-1:0]      ul_hist [MAX_PIXEL_BYTES];
	logic [FILT_W-1:0]      row_filt = FILT_NONE;
	int                     col_pos = 0;
	logic                   await_type = 1'b1;

	pix_t pending_pixels [$];
	int   mismatch_cnt = 0;
	int   cycle_cnt = 0;
	int   burst_left = 0;
	logic hold_req = 1'b0;
	bit   hold_done = 1'b0;

	dir_row_t dir_tab [DIR_N] = '{
		'{DIR_BYTE, '0, 15'(FILT_NONE), 1'b0, '0},
		'{DIR_BYTE, '0, 15'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{DIR_BYTE, '0, 15'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0}},
		'{DIR_BYTE, '0, 15'h80, 1'b1, '{8'h80, 1'b1, 1'b0}},
		'{DIR_BYTE, '0, 15'hFF, 1'b0, '0},
		'{DIR_BYTE, '0, 15'h12, 1'b1, '{8'h12, 1'b0, 1'b1}},
		'{DIR_BYTE, '0, 15'h34, 1'b1, '{8'h34, 1'b0, 1'b1}},
		'{DIR_BYTE, '0, 15'h56, 1'b1, '{8'h56, 1'b1, 1'b1}},
		'{DIR_BYTE, '0, 15'(FILT_UP), 1'b0, '0},
		'{DIR_BYTE, '0, 15'hFF, 1'b1, '{8'h11, 1'b0, 1'b0}},
		'{DIR_BYTE, '0, 15'hFE, 1'b1, '{8'h32, 1'b0, 1'b0}},
		'{DIR_BYTE, '0, 15'h00, 1'b1, '{8'h56, 1'b1, 1'b0}},
		'{DIR_REG, REG_BPP, 15'h7FFF, 1'b0, '0},
		'{DIR_REG, REG_ROW_BYTES, 15'h0000, 1'b0, '0},
		'{DIR_REG, REG_UNUSED2, 15'h1234, 1'b0, '0},
		'{DIR_REG, REG_UNUSED3, 15'h7FFF, 1'b0, '0},
		'{DIR_BYTE, '0, 15'(FILT_SUB), 1'b0, '0},
		'{DIR_BYTE, '0, 15'h40, 1'b1, '{8'h40, 1'b1, 1'b0}},
		'{DIR_BYTE, '0, 15'(FILT_AVG), 1'b0, '0},
		'{DIR_BYTE, '0, 15'h20, 1'b1, '{8'h40, 1'b1, 1'b0}},
		'{DIR_REG, REG_ROW_BYTES, 15'd6, 1'b0, '0},
		'{DIR_REG, REG_BPP, 15'd0, 1'b0, '0},
		'{DIR_BYTE, '0, 15'(FILT_PAETH), 1'b0, '0},
		'{DIR_BYTE, '0, 15'h7F, 1'b0, '0},
		'{DIR_BYTE, '0, 15'h80, 1'b0, '0},
		'{DIR_BYTE, '0, 15'h01, 1'b0, '0},
		'{DIR_BYTE, '0, 15'hFE, 1'b0, '0},
		'{DIR_BYTE, '0, 15'h00, 1'b0, '0},
		'{DIR_BYTE, '0, 15'hFF, 1'b0, '0}
	};

	png_scanline_unfilter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stream_byte (stream_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_byte  (pixel_byte),
		.row_end     (row_end),
		.bad_filter  (bad_filter)
	);

	always #4 clk = ~clk;

	function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
			input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] c);
		int ia, ib, ic, p, da, db, dc;
		ia = a;
		ib = b;
		ic = c;
		p = ia + ib - ic;
		da = (p >= ia) ? p - ia : ia - p;
		db = (p >= ib) ? p - ib : ib - p;
		dc = (p >= ic) ? p - ic : ic - p;
		if (da <= db && da <= dc)
			return a;
		else if (db <= dc)
			return b;
		return c;
	endfunction

	// advance the predictor by one accepted stream byte
	task automatic unfilter_step(input logic [BYTE_W-1:0] b, output logic made,
			output pix_t res);
		int len, bpp, pos, k;
		logic [BYTE_W-1:0] up, lft, ul, pred;
		logic hl;
		len = (rowlen_reg == 0) ? 1 :
			((rowlen_reg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(rowlen_reg));
		bpp = (bpp_reg == 0) ? 1 :
			((bpp_reg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(bpp_reg));
		made = 1'b0;
		res = '0;
		if (await_type) begin
			row_filt = (b <= 8'(FILT_PAETH)) ? b[FILT_W-1:0] : FILT_BAD;
			col_pos = 0;
			await_type = 1'b0;
		end else begin
			pos = (col_pos >= len) ? len - 1 : col_pos;
			hl = pos >= bpp;
			up = prev_line[pos];
			lft = hl ? left_hist[bpp-1] : 8'h00;
			ul = hl ? ul_hist[bpp-1] : 8'h00;
			case (row_filt)
				FILT_SUB:   pred = lft;
				FILT_UP:    pred = up;
				FILT_AVG:   pred = 8'((int'(lft) + int'(up)) >> 1);
				FILT_PAETH: pred = paeth_pick(lft, up, ul);
				default:    pred = 8'h00;
			endcase
			res.pixel = b + pred;
			for (k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
				left_hist[k] = left_hist[k-1];
				ul_hist[k] = ul_hist[k-1];
			end
			left_hist[0] = res.pixel;
			ul_hist[0] = up;
			prev_line[pos] = res.pixel;
			res.last = (pos + 1) >= len;
			res.bad = (row_filt == FILT_BAD);
			made = 1'b1;
			if (res.last) begin
				col_pos = 0;
				await_type = 1'b1;
			end else begin
				col_pos = pos + 1;
			end
		end
	endtask

	function automatic logic [BYTE_W-1:0] next_stream_byte();
		logic [BYTE_W-1:0] v;
		if (await_type) begin
			v = ($urandom_range(0, 7) != 0) ? 8'($urandom_range(FILT_NONE, FILT_PAETH)) :
				8'($urandom_range(FILT_BAD, 255));
		end else begin
			case ($urandom_range(0, 9))
				0:       v = 8'h00;
				1:       v = 8'hFF;
				default: v = 8'($urandom_range(0, 255));
			endcase
		end
		return v;
	endfunction

	// offer one byte, with burst/gap pacing, and queue its expected pixel if it makes one
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed, input pix_t want);
		int gap;
		logic made;
		pix_t got;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 64);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (!in_ready);
		unfilter_step(b, made, got);
		if (made)
			pending_pixels.push_back(typed ? want : got);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [ROW_BYTES_W-1:0] val, input logic more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_ROW_BYTES)
			rowlen_reg = val;
		else if (idx == REG_BPP)
			bpp_reg = val[BPP_W-1:0];
		if (!more)
			cfg_valid <= 1'b0;
	endtask

	// a filter byte makes no output, so also idle after the last expected pixel is out
	task automatic drain_idle();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (LAT_IDLE) @(posedge clk);
	endtask

	initial begin : stim
		int i, phase, n, rand_items;
		logic prev_reg, spare;
		logic [ROW_BYTES_W-1:0] rb;
		logic [BPP_W-1:0] bv;
		for (i = 0; i < MAX_ROW_BYTES; i++)
			prev_line[i] = 8'h00;
		for (i = 0; i < MAX_PIXEL_BYTES; i++) begin
			left_hist[i] = 8'h00;
			ul_hist[i] = 8'h00;
		end
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		stream_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_reg = 1'b0;
		for (i = 0; i < DIR_N; i++) begin
			if (dir_tab[i].kind == DIR_REG) begin
				if (!prev_reg)
					drain_idle();
				cfg_write(dir_tab[i].idx, dir_tab[i].val,
					(i + 1 < DIR_N) && (dir_tab[i+1].kind == DIR_REG));
				prev_reg = 1'b1;
			end else begin
				send_byte(dir_tab[i].val[BYTE_W-1:0], dir_tab[i].typed, dir_tab[i].want);
				prev_reg = 1'b0;
			end
		end

		// random phases; each starts from idle and may land mid-row
		phase = 0;
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			drain_idle();
			case ($urandom_range(0, 7))
				0:       rb = 15'd0;
				1:       rb = 15'd1;
				2:       rb = 15'd2;
				default: rb = 15'($urandom_range(3, 40));
			endcase
			if (phase == 4)
				rb = '1;   // widest setting, clamps to the longest row
			case (phase)
				0:       bv = 4'd8;
				1:       bv = 4'd1;
				default: bv = 4'($urandom_range(0, 15));
			endcase
			spare = ($urandom_range(0, 3) == 0);
			cfg_write(REG_ROW_BYTES, rb, 1'b1);
			cfg_write(REG_BPP, {11'($urandom), bv}, spare);
			if (spare)
				cfg_write($urandom_range(0, 1) ? REG_UNUSED2 : REG_UNUSED3,
					15'($urandom), 1'b0);
			if (phase == 2)
				hold_req <= 1'b1;
			n = (phase == 2) ? 240 : $urandom_range(40, 200);
			repeat (n) begin
				send_byte(next_stream_byte(), 1'b0, '0);
				rand_items++;
			end
			phase++;
		end

		drain_idle();
		if (mismatch_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// receiver: stall patterns by segment, plus one long hold-off on request
	initial begin : rx
		int seg_left;
		rx_mode_t rx_mode;
		seg_left = 0;
		rx_mode = RX_FREE;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (seg_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(8, 80);
				end
				seg_left--;
				case (rx_mode)
					RX_FREE:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= !out_ready;
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : chk
		pix_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected output transfer: pixel_byte %02h row_end %0b bad_filter %0b",
						pixel_byte, row_end, bad_filter);
			end else begin
				e = pending_pixels.pop_front();
				if (pixel_byte !== e.pixel || row_end !== e.last || bad_filter !== e.bad) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: pixel exp %02h got %02h, last exp %0b got %0b, bad exp %0b got %0b",
							e.pixel, pixel_byte, e.last, row_end, e.bad, bad_filter);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end
endmodule

FILE: sim.f
+incdir+rtl
rtl/pngu_pkg.sv
rtl/pngu_ram.sv
rtl/pngu_recon.sv
rtl/png_scanline_unfilter_top.sv
tb/sv/tb_png_scanline_unfilter_top.sv
